>>> src/prwf_pkg.sv
`default_nettype none
package prwf_pkg;

    localparam int CodeW   = 6;
    localparam int MomW    = 24;
    localparam int RapW    = 20;
    localparam int CountW  = 10;
    localparam int WinW    = 19;
    localparam int WideW   = 48;
    localparam int LogFrac = 24;
    localparam int LogW    = 30;
    localparam int StepW   = 5;

    localparam logic [CodeW-1:0]  PROTON_CODE  = 6'd14;
    localparam logic [WideW-1:0]  MASS_SQ      = 48'd3781389049;
    localparam logic [31:0]       LN2_Q30      = 32'd744261118;
    localparam logic [WinW-1:0]   WINDOW_RESET = 19'd47186;
    localparam logic [CountW-1:0] TALLY_MAX    = 10'd1023;
    localparam logic [StepW-1:0]  SQRT_STEPS   = 5'd24;
    localparam logic [StepW-1:0]  LOG_STEPS    = 5'd24;

    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_LOAD      = 4'd1;
    localparam logic [3:0] OP_SQX       = 4'd2;
    localparam logic [3:0] OP_SQY       = 4'd3;
    localparam logic [3:0] OP_SQZ       = 4'd4;
    localparam logic [3:0] OP_SQRT      = 4'd5;
    localparam logic [3:0] OP_LOG1_INIT = 4'd6;
    localparam logic [3:0] OP_NORM      = 4'd7;
    localparam logic [3:0] OP_LOG_STEP  = 4'd8;
    localparam logic [3:0] OP_LOG2_INIT = 4'd9;
    localparam logic [3:0] OP_DIFF      = 4'd10;
    localparam logic [3:0] OP_SCALE     = 4'd11;
    localparam logic [3:0] OP_FINISH    = 4'd12;

    typedef struct packed {
        logic [3:0] op;
    } cmd_t;

    typedef struct packed {
        logic skip;
        logic norm_done;
    } status_t;

endpackage
`default_nettype wire

>>> src/prwf_ctrl.sv
`default_nettype none
module prwf_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  wire                 m_tready,
    input  prwf_pkg::status_t   status,
    output prwf_pkg::cmd_t      cmd
);
    import prwf_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SQX    = 4'd1;
    localparam logic [3:0] S_SQY    = 4'd2;
    localparam logic [3:0] S_SQZ    = 4'd3;
    localparam logic [3:0] S_SQRT   = 4'd4;
    localparam logic [3:0] S_L1INIT = 4'd5;
    localparam logic [3:0] S_NORM1  = 4'd6;
    localparam logic [3:0] S_LOG1   = 4'd7;
    localparam logic [3:0] S_L2INIT = 4'd8;
    localparam logic [3:0] S_NORM2  = 4'd9;
    localparam logic [3:0] S_LOG2   = 4'd10;
    localparam logic [3:0] S_DIFF   = 4'd11;
    localparam logic [3:0] S_SCALE  = 4'd12;
    localparam logic [3:0] S_FINISH = 4'd13;

    logic [3:0]       state_reg, state_next;
    logic [StepW-1:0] cnt_reg, cnt_next;
    logic             ovalid_reg, ovalid_next;
    logic             out_free;

    assign out_free = !ovalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = ovalid_reg;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        ovalid_next = ovalid_reg && !m_tready;
        cmd.op      = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_SQX;
                end
            end
            S_SQX:
            begin
                cmd.op     = OP_SQX;
                state_next = status.skip ? S_FINISH : S_SQY;
            end
            S_SQY:
            begin
                cmd.op     = OP_SQY;
                state_next = S_SQZ;
            end
            S_SQZ:
            begin
                cmd.op     = OP_SQZ;
                cnt_next   = '0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.op   = OP_SQRT;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == SQRT_STEPS - 1'b1)
                    state_next = S_L1INIT;
            end
            S_L1INIT:
            begin
                cmd.op     = OP_LOG1_INIT;
                state_next = S_NORM1;
            end
            S_NORM1, S_NORM2:
            begin
                // normalise; the cycle that sees the top bit set loads z
                cmd.op   = OP_NORM;
                cnt_next = '0;
                if (status.norm_done)
                    state_next = (state_reg == S_NORM1) ? S_LOG1 : S_LOG2;
            end
            S_LOG1, S_LOG2:
            begin
                cmd.op   = OP_LOG_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LOG_STEPS - 1'b1)
                    state_next = (state_reg == S_LOG1) ? S_L2INIT : S_DIFF;
            end
            S_L2INIT:
            begin
                cmd.op     = OP_LOG2_INIT;
                state_next = S_NORM2;
            end
            S_DIFF:
            begin
                cmd.op     = OP_DIFF;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.op     = OP_SCALE;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    cmd.op      = OP_FINISH;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule
`default_nettype wire

>>> src/prwf_dp.sv
`default_nettype none
module prwf_dp (
    input  wire                          clk,
    input  wire                          rst_n,
    input  prwf_pkg::cmd_t               cmd,
    output prwf_pkg::status_t            status,
    input  wire                          cfg_we,
    input  wire [prwf_pkg::WinW-1:0]     cfg_wdata,
    input  wire [prwf_pkg::CodeW-1:0]    in_code,
    input  wire [prwf_pkg::MomW-1:0]     in_x,
    input  wire [prwf_pkg::MomW-1:0]     in_y,
    input  wire [prwf_pkg::MomW-1:0]     in_z,
    input  wire                          in_last,
    output logic                         out_accepted,
    output logic [prwf_pkg::RapW-1:0]    out_rapidity,
    output logic [prwf_pkg::CountW-1:0]  out_count,
    output logic                         out_last
);
    import prwf_pkg::*;

    logic [CodeW-1:0]  code_reg;
    logic [MomW-1:0]   ax_reg, ay_reg, az_reg;
    logic              neg_reg, last_reg;
    logic [WideW-1:0]  acc_reg, mt2_reg, rem_reg, res_reg, bit_reg, w_reg;
    logic [5:0]        k_reg;
    logic [31:0]       z_reg;
    logic [LogFrac-1:0] frac_reg;
    logic [LogW-1:0]   l1_reg;
    logic [30:0]       d_reg;
    logic [RapW-1:0]   mag_reg;
    logic [WinW-1:0]   window_reg;
    logic [CountW-1:0] tally_reg;

    logic [31:0]       mul_a, mul_b;
    logic [63:0]       prod;
    logic [WideW:0]    trial;
    logic [32:0]       sq;
    logic [31:0]       dsum;
    logic [63:0]       rounded;
    logic [24:0]       mag_full;
    logic [RapW-1:0]   yabs, yval;
    logic              acc_flag, proton;
    logic [CountW-1:0] tally_new;

    function automatic logic [MomW-1:0] abs24(input logic [MomW-1:0] v);
        abs24 = v[MomW-1] ? (~v + 1'b1) : v;
    endfunction

    assign proton           = (code_reg == PROTON_CODE);
    assign status.skip      = !proton || (az_reg == '0);
    assign status.norm_done = w_reg[WideW-1];

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_SQX:      begin mul_a = {8'd0, ax_reg}; mul_b = {8'd0, ax_reg}; end
            OP_SQY:      begin mul_a = {8'd0, ay_reg}; mul_b = {8'd0, ay_reg}; end
            OP_SQZ:      begin mul_a = {8'd0, az_reg}; mul_b = {8'd0, az_reg}; end
            OP_LOG_STEP: begin mul_a = z_reg;          mul_b = z_reg;          end
            OP_SCALE:    begin mul_a = {1'b0, d_reg};  mul_b = LN2_Q30;        end
            default:     begin mul_a = '0;             mul_b = '0;             end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign trial    = {1'b0, res_reg} + {1'b0, bit_reg};
    assign sq       = prod[63:31];
    assign dsum     = {1'b0, l1_reg, 1'b0} - {2'b0, k_reg, frac_reg};
    assign rounded  = prod + 64'h0000_0040_0000_0000;
    assign mag_full = rounded[63:39];

    always_comb
    begin
        if (!neg_reg && mag_reg == 20'h80000)
            yabs = 20'h7FFFF;
        else
            yabs = mag_reg;
        yval     = neg_reg ? (20'd0 - mag_reg) : yabs;
        acc_flag = (yabs <= {1'b0, window_reg});
        if (status.skip)
        begin
            yval     = '0;
            acc_flag = proton;
        end
        tally_new = (acc_flag && tally_reg != TALLY_MAX) ? tally_reg + 1'b1 : tally_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
            tally_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
                window_reg <= cfg_wdata;
            if (cmd.op == OP_FINISH)
                tally_reg <= last_reg ? '0 : tally_new;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                code_reg <= in_code;
                ax_reg   <= abs24(in_x);
                ay_reg   <= abs24(in_y);
                az_reg   <= abs24(in_z);
                neg_reg  <= in_z[MomW-1];
                last_reg <= in_last;
            end
            OP_SQX: acc_reg <= MASS_SQ + prod[WideW-1:0];
            OP_SQY: acc_reg <= acc_reg + prod[WideW-1:0];
            OP_SQZ:
            begin
                mt2_reg <= acc_reg;
                rem_reg <= acc_reg + prod[WideW-1:0];
                res_reg <= '0;
                bit_reg <= 48'h4000_0000_0000;
            end
            OP_SQRT:
            begin
                if ({1'b0, rem_reg} >= trial)
                begin
                    rem_reg <= rem_reg - trial[WideW-1:0];
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                    res_reg <= res_reg >> 1;
                bit_reg <= bit_reg >> 2;
            end
            OP_LOG1_INIT:
            begin
                w_reg <= {23'd0, {1'b0, res_reg[MomW-1:0]} + {1'b0, az_reg}};
                k_reg <= 6'd47;
            end
            OP_LOG2_INIT:
            begin
                l1_reg <= {k_reg, frac_reg};
                w_reg  <= mt2_reg;
                k_reg  <= 6'd47;
            end
            OP_NORM:
            begin
                if (w_reg[WideW-1])
                    z_reg <= w_reg[WideW-1:16];
                else if (w_reg[WideW-1:WideW-8] == '0)
                begin
                    w_reg <= w_reg << 8;
                    k_reg <= k_reg - 6'd8;
                end
                else
                begin
                    w_reg <= w_reg << 1;
                    k_reg <= k_reg - 6'd1;
                end
            end
            OP_LOG_STEP:
            begin
                if (sq[32])
                    z_reg <= sq[32:1];
                else
                    z_reg <= sq[31:0];
                frac_reg <= {frac_reg[LogFrac-2:0], sq[32]};
            end
            OP_DIFF: d_reg <= dsum[31] ? '0 : dsum[30:0];
            OP_SCALE: mag_reg <= (mag_full > 25'd524288) ? 20'h80000 : mag_full[RapW-1:0];
            OP_FINISH:
            begin
                out_accepted <= acc_flag;
                out_rapidity <= yval;
                out_count    <= tally_new;
                out_last     <= last_reg;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

>>> src/proton_rapidity_window_filter_top.sv
// Proton rapidity window filter.
// Input stream: one track per word on s_*; s_tdata carries particle code and
// the three momentum components, s_tlast marks the last track of an event.
// Output stream: one word per track on m_*; m_tdata carries the accept flag,
// the signed Q4.16 rapidity and the event proton count, m_tlast echoes s_tlast.
// Window: cfg_we writes cfg_wdata (unsigned Q3.16 half width).
// A non-proton or a proton with zero pz goes from the first squaring
// straight to the output step; otherwise the track passes three squarings
// on the shared 32x32 multiplier, a 24-step square root, two logarithms of
// 24 squaring steps each behind a normalising shift, then the scale by ln2.
// One track is in work at a time and the next word is taken in the cycle
// after the result is registered.
// Reset returns the window to 0.72 and clears the event count and the
// output valid.
// A stalled receiver holds the result in the output register; the block
// still takes and works on the next track, and waits in its last step only
// if the previous word has not been taken.
`default_nettype none
module proton_rapidity_window_filter_top (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [79:0] s_tdata,   // particle_code[5:0], mom_x[29:6], mom_y[53:30], mom_z[77:54]
    input  wire         s_tlast,
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // accepted[0], rapidity_value[20:1], proton_count[30:21]
    output logic        m_tlast,
    input  wire         cfg_we,
    input  wire  [18:0] cfg_wdata
);
    import prwf_pkg::*;

    cmd_t              cmd;
    status_t           status;
    logic              accepted;
    logic [RapW-1:0]   rapidity_value;
    logic [CountW-1:0] proton_count;

    prwf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    prwf_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_code      (s_tdata[5:0]),
        .in_x         (s_tdata[29:6]),
        .in_y         (s_tdata[53:30]),
        .in_z         (s_tdata[77:54]),
        .in_last      (s_tlast),
        .out_accepted (accepted),
        .out_rapidity (rapidity_value),
        .out_count    (proton_count),
        .out_last     (m_tlast)
    );

    assign m_tdata = {1'b0, proton_count, rapidity_value, accepted};

endmodule
`default_nettype wire

>>> src/prwf_checker.sv
`default_nettype none
module prwf_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [31:0] m_tdata,
    input wire        m_tlast
);

    // stalled word stays
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // an accepted proton is always counted
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[30:21] != 10'd0)
        else $error("accepted track with zero count");

    // one track in work at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken twice in a row");

endmodule

bind proton_rapidity_window_filter_top prwf_checker u_prwf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire
